// ----- hdl/cca_pkg.sv -----
// Shared types and codes for the contiguous cell allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package cca_pkg;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FILL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_run;
    logic fill_init;
    logic fill_run;
    logic clear_run;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_release;
    logic req_ok;
    logic scan_done;
    logic found;
    logic fill_last;
    logic clear_last;
  } dp_status_t;

endpackage

// ----- hdl/cca_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module cca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/cca_ctrl.sv -----
// Controller state machine of the cell allocator: sequences clear, decode, scan, fill and result.
// Depends on cca_pkg for the state type and the command and status structs.
module cca_ctrl
  import cca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    ctl,
  input  dp_status_t status
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        ctl.clear_run = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_release || status.req_ok) begin
          ctl.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          if (!status.is_release && status.found) begin
            ctl.fill_init = 1'b1;
            state_next    = ST_FILL;
          end else begin
            state_next = ST_RESULT;
          end
        end else begin
          ctl.scan_run = 1'b1;
        end
      end
      ST_FILL: begin
        ctl.fill_run = 1'b1;
        if (status.fill_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_DECODE))
    else $error("accepted request did not enter decode");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.scan_init, ctl.scan_run, ctl.fill_init,
              ctl.fill_run, ctl.clear_run, ctl.finish}))
    else $error("more than one datapath command in a cycle");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_RESULT))
    else $error("result appeared outside the result state");

endmodule

// ----- hdl/cca_dp.sv -----
// Datapath of the cell allocator: cell map RAM, scan and fill counters, fit tracking,
// policy and pointer registers and the result register. Depends on cca_pkg and cca_ram.
module cca_dp
  import cca_pkg::*;
#(
  parameter int MAP_CELLS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        req_cmd,
  input  logic [7:0]  req_owner,
  input  logic [7:0]  req_size,
  input  dp_cmd_t     ctl,
  output dp_status_t  status,
  output logic        granted,
  output logic [6:0]  base_cell,
  output logic [15:0] alloc_total
);

  localparam int CW = $clog2(MAP_CELLS);
  localparam int PW = $clog2(MAP_CELLS + 1);
  localparam int SW = (PW > 8) ? PW : 8;
  localparam logic [SW-1:0] CELLS_S = SW'(MAP_CELLS);
  localparam logic [PW-1:0] CELLS_P = PW'(MAP_CELLS);
  localparam logic [CW-1:0] LAST_C  = CW'(MAP_CELLS - 1);
  localparam logic [PW-1:0] LAST_P  = PW'(MAP_CELLS - 1);

  logic [1:0]    policy;
  logic          is_rel;
  logic [7:0]    owner;
  logic [PW-1:0] len;
  logic          req_ok;
  logic [PW-1:0] nf_ptr;
  logic [15:0]   count;

  logic [CW-1:0] rd_addr;
  logic [PW-1:0] issued;
  logic          dv;
  logic [CW-1:0] dv_idx;
  logic [PW-1:0] proc_cnt;
  logic [PW-1:0] run, run_next;
  logic          have, have_next;
  logic [PW-1:0] best_len, best_len_next;
  logic [CW-1:0] best_base, best_base_next;
  logic          found, found_next;
  logic          exhausted, exhausted_next;
  logic          tail_pend, tail_pend_next;
  logic [CW-1:0] base, base_next;
  logic [CW-1:0] fill_addr;
  logic [PW-1:0] fill_cnt;
  logic [CW-1:0] clr_addr;

  logic          out_granted;
  logic [CW-1:0] out_base;
  logic [CW+6:0] out_base_w;

  logic          we;
  logic [CW-1:0] waddr;
  logic [7:0]    wdata;
  logic          rd_en;
  logic [7:0]    rdata;

  logic          best_mode;
  logic          active;
  logic          tail;
  logic          cell_free;
  logic [PW-1:0] idx_p;
  logic [PW-1:0] run_eff;
  logic [PW-1:0] run_inc;
  logic [PW-1:0] run_c;
  logic [PW-1:0] close_pos;
  logic          do_close;
  logic [CW-1:0] start_addr;

  cca_ram #(
    .WIDTH (8),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign best_mode = !is_rel && (policy == FIT_BEST);
  assign active    = ctl.scan_run && dv && !found && !exhausted && !tail_pend;
  assign tail      = ctl.scan_run && tail_pend && !found && !exhausted;
  assign cell_free = (rdata == 8'd0);
  assign idx_p     = PW'(dv_idx);
  assign run_eff   = (dv_idx == '0) ? '0 : run;
  assign run_inc   = run_eff + PW'(1);
  assign rd_en     = ctl.scan_run && (issued != CELLS_P);

  // Next fit resumes at the pointer; a pointer at the end of the map means cell 0.
  always_comb begin
    if (!is_rel && (policy == FIT_NEXT) && (nf_ptr != CELLS_P)) begin
      start_addr = nf_ptr[CW-1:0];
    end else begin
      start_addr = '0;
    end
  end

  // One map cell is examined per cycle; best fit closes a hole at each used cell
  // and once more at the end of the map.
  always_comb begin
    run_next       = run;
    have_next      = have;
    best_len_next  = best_len;
    best_base_next = best_base;
    found_next     = found;
    exhausted_next = exhausted;
    tail_pend_next = tail_pend;
    base_next      = base;
    do_close       = 1'b0;
    run_c          = tail ? run : run_eff;
    close_pos      = tail ? CELLS_P : idx_p;

    if (active) begin
      if (best_mode) begin
        if (cell_free) begin
          run_next = run_inc;
        end else begin
          do_close = 1'b1;
        end
      end else if (!is_rel) begin
        if (cell_free) begin
          run_next = run_inc;
          if (run_inc == len) begin
            found_next = 1'b1;
            base_next  = CW'(idx_p + PW'(1) - len);
          end
        end else begin
          run_next = '0;
        end
      end
      if (proc_cnt == LAST_P) begin
        if (best_mode) begin
          tail_pend_next = 1'b1;
        end else begin
          exhausted_next = 1'b1;
        end
      end
    end

    if (tail) begin
      do_close       = 1'b1;
      tail_pend_next = 1'b0;
      exhausted_next = 1'b1;
    end

    if (do_close) begin
      run_next = '0;
      if (run_c == len) begin
        found_next = 1'b1;
        base_next  = CW'(close_pos - len);
      end else if ((run_c > len) && (!have || (run_c < best_len))) begin
        have_next      = 1'b1;
        best_len_next  = run_c;
        best_base_next = CW'(close_pos - run_c);
      end
    end

    if (tail && !found_next && have_next) begin
      found_next = 1'b1;
      base_next  = best_base_next;
    end
  end

  // Write port: reset clearing pass, run fill, or freeing a released owner's cell.
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = 8'd0;
    if (ctl.clear_run) begin
      we = 1'b1;
    end else if (ctl.fill_run) begin
      we    = 1'b1;
      waddr = fill_addr;
      wdata = owner;
    end else if (active && is_rel && (rdata == owner)) begin
      we    = 1'b1;
      waddr = dv_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= FIT_FIRST;
      nf_ptr    <= '0;
      count     <= '0;
      clr_addr  <= '0;
      dv        <= 1'b0;
      found     <= 1'b0;
      exhausted <= 1'b0;
      tail_pend <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy <= cfg_wr_data;
      end
      if (ctl.clear_run) begin
        clr_addr <= (clr_addr == LAST_C) ? '0 : clr_addr + CW'(1);
      end

      if (ctl.load) begin
        is_rel    <= (req_cmd == CMD_RELEASE);
        owner     <= req_owner;
        len       <= PW'(req_size);
        req_ok    <= (req_size != 8'd0) && (SW'(req_size) <= CELLS_S) && (req_owner != 8'd0);
        found     <= 1'b0;
        exhausted <= 1'b0;
        tail_pend <= 1'b0;
      end else if (ctl.scan_init) begin
        rd_addr   <= start_addr;
        issued    <= '0;
        dv        <= 1'b0;
        proc_cnt  <= '0;
        run       <= '0;
        have      <= 1'b0;
        found     <= 1'b0;
        exhausted <= 1'b0;
        tail_pend <= 1'b0;
      end else begin
        dv     <= rd_en;
        dv_idx <= rd_addr;
        if (rd_en) begin
          rd_addr <= (rd_addr == LAST_C) ? '0 : rd_addr + CW'(1);
          issued  <= issued + PW'(1);
        end
        if (active) begin
          proc_cnt <= proc_cnt + PW'(1);
        end
        run       <= run_next;
        have      <= have_next;
        best_len  <= best_len_next;
        best_base <= best_base_next;
        found     <= found_next;
        exhausted <= exhausted_next;
        tail_pend <= tail_pend_next;
        base      <= base_next;
      end

      if (ctl.fill_init) begin
        fill_addr <= base;
        fill_cnt  <= '0;
      end else if (ctl.fill_run) begin
        fill_addr <= fill_addr + CW'(1);
        fill_cnt  <= fill_cnt + PW'(1);
      end

      if (ctl.finish) begin
        if (is_rel) begin
          out_granted <= 1'b1;
          out_base    <= '0;
          alloc_total <= count;
        end else if (found) begin
          out_granted <= 1'b1;
          out_base    <= base;
          alloc_total <= count + 16'd1;
          count       <= count + 16'd1;
          if (policy == FIT_NEXT) begin
            nf_ptr <= PW'(base) + len;
          end
        end else begin
          out_granted <= 1'b0;
          out_base    <= '0;
          alloc_total <= count;
          if (policy == FIT_NEXT) begin
            nf_ptr <= '0;
          end
        end
      end
    end
  end

  assign out_base_w = {7'd0, out_base};
  assign granted    = out_granted;
  assign base_cell  = out_base_w[6:0];

  assign status.is_release = is_rel;
  assign status.req_ok     = req_ok;
  assign status.scan_done  = found || exhausted;
  assign status.found      = found;
  assign status.fill_last  = (fill_cnt == len - PW'(1));
  assign status.clear_last = (clr_addr == LAST_C);

  a_fill_needs_fit: assert property (@(posedge clk) disable iff (rst)
    ctl.fill_run |-> (found && !is_rel))
    else $error("fill running without a placed run");

  a_tail_after_data: assert property (@(posedge clk) disable iff (rst)
    (ctl.scan_run && tail_pend) |-> !dv)
    else $error("best fit end-of-map close overlaps cell data");

endmodule

// ----- hdl/contiguous_cell_allocator_unit.sv -----
// Top level of the contiguous cell allocator: a controller and a datapath.
// Depends on cca_pkg, cca_ctrl, cca_dp (and through it cca_ram).
//
// Usage: requests arrive on the input channel (in_valid, in_stall) with cmd, owner_id and
// req_size. An allocate request (cmd 0) looks for a run of req_size free cells under the
// placement rule held in the fit policy register, written through cfg_wr_en/cfg_wr_data
// while the block is idle (0 first fit, 1 next fit, 2 best fit, 3 acts as first fit).
// A release request (cmd 1) frees every cell that holds owner_id. Each request gives one
// result on the output channel (out_valid, out_stall): granted, base_cell, alloc_total.
//
// Sequencing: one request at a time. The map is read one cell per cycle during a scan,
// and a granted run is then written one cell per cycle before the result step. A refused
// request (bad size or owner zero) goes from decode straight to the result step, and
// in_stall drops in the same cycle that out_valid rises.
//
// Reset: rst is synchronous. After it the block clears the map, one cell per cycle, with
// in_stall high; configuration writes are taken meanwhile.
// Stalls: the result sits in an output register, so the next request is taken while it
// waits. A finished request holds in its result step until the output register is free.
module contiguous_cell_allocator_unit
  import cca_pkg::*;
#(
  parameter int MAP_CELLS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  owner_id,
  input  logic [7:0]  req_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        granted,
  output logic [6:0]  base_cell,
  output logic [15:0] alloc_total
);

  // Commands from the controller and status back from the datapath.
  dp_cmd_t    ctl;
  dp_status_t status;

  cca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .status    (status)
  );

  // The datapath latches the request when the controller accepts it, so the
  // payload ports are only sampled in that cycle.
  cca_dp #(
    .MAP_CELLS (MAP_CELLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_cmd     (cmd),
    .req_owner   (owner_id),
    .req_size    (req_size),
    .ctl         (ctl),
    .status      (status),
    .granted     (granted),
    .base_cell   (base_cell),
    .alloc_total (alloc_total)
  );

  // A refused allocation always reports cell zero.
  a_refused_base_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (base_cell == 7'd0))
    else $error("refused request reported a nonzero base cell");

endmodule
